// File: rtl/core/wkl_pkg.sv
package wkl_pkg;

    localparam int CFG_W = 48;

    // Opcodes of an input request
    localparam logic [1:0] OP_CHECK   = 2'd0;
    localparam logic [1:0] OP_SWEEP   = 2'd1;
    localparam logic [1:0] OP_REWRITE = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_TIMEOUT    = 3'd0;
    localparam logic [2:0] REG_ETHER_TYPE = 3'd1;
    localparam logic [2:0] REG_LENGTH     = 3'd2;
    localparam logic [2:0] REG_DEST_MAC   = 3'd3;
    localparam logic [2:0] REG_INSTANCE   = 3'd4;

    // Configuration reset values
    localparam logic [7:0]  RST_TIMEOUT    = 8'd2;
    localparam logic [15:0] RST_ETHER_TYPE = 16'h9000;
    localparam logic [13:0] RST_LENGTH     = 14'd18;
    localparam logic [47:0] RST_DEST_MAC   = 48'hFF00_0000_0000;
    localparam logic [23:0] RST_INSTANCE   = 24'd0;

    localparam logic [23:0] SRC_PREFIX = 24'hBADA55;

    // Command kinds handed from front to back
    localparam logic [1:0] CMD_NONE      = 2'd0;
    localparam logic [1:0] CMD_KEEPALIVE = 2'd1;
    localparam logic [1:0] CMD_SWEEP     = 2'd2;
    localparam logic [1:0] CMD_REWRITE   = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [13:0] frame_length;
        logic [15:0] frame_ether_type;
        logic [47:0] frame_dest_mac;
        logic [47:0] frame_src_mac;
        logic [31:0] reported_delay_ms;
        logic [31:0] now_seconds;
    } t_in_req;

    typedef struct packed {
        logic        is_keepalive;
        logic        table_full;
        logic        worker_valid;
        logic [47:0] worker_mac;
        logic [47:0] rewritten_src_mac;
        logic        drop_frame;
    } t_out_req;

    typedef struct packed {
        logic [7:0]  timeout_seconds;
        logic [15:0] keepalive_ether_type;
        logic [13:0] keepalive_length;
        logic [47:0] keepalive_dest_mac;
        logic [23:0] instance_id;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic        is_keepalive;
        logic [47:0] mac;
        logic [31:0] delay;
        logic [31:0] now;
    } t_cmd;

    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] last_seen;
        logic [31:0] delay;
    } t_slot;

endpackage

// File: rtl/core/worker_keepalive_table_least_delay_top.sv
// Worker keepalive table with least-delay selection.
// Request channel: drive i_req and raise push; a request is taken at a clock edge
// with push high and full low. Result channel: while empty is low the oldest
// result sits on o_res; raise pop to take it. Every request gives exactly one
// result, in request order.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at the edge
// (0 timeout, 1 keepalive ether type, 2 keepalive length, 3 keepalive destination
// MAC, 4 instance id); write only while no request is in flight.
// Sequencing: a matching keepalive or a sweep walks the slot memory, one slot per
// cycle through its registered read port; any other request skips the walk.
// The back end runs one command at a time; a two-entry command queue lets the
// front keep accepting meanwhile.
// Reset clears all valid bits and the selection and loads the register defaults.
// When the receiver holds off pop, results collect in a two-entry output queue,
// then the back end stalls, then the command queue fills and full rises.
module worker_keepalive_table_least_delay_top
    import wkl_pkg::*;
#(
    parameter int MAX_WORKERS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  t_in_req          i_req,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output t_out_req         o_res,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cfg     r_cfg;
    t_cmd     w_cmd;
    t_cmd     w_q_cmd;
    logic     w_q_empty;
    logic     w_cmd_pop;
    logic     w_res_full;
    t_out_req w_res;
    logic     w_res_push;

    // Hold configuration; drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_seconds      <= RST_TIMEOUT;
            r_cfg.keepalive_ether_type <= RST_ETHER_TYPE;
            r_cfg.keepalive_length     <= RST_LENGTH;
            r_cfg.keepalive_dest_mac   <= RST_DEST_MAC;
            r_cfg.instance_id          <= RST_INSTANCE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TIMEOUT:    r_cfg.timeout_seconds      <= i_cfg_data[7:0];
                REG_ETHER_TYPE: r_cfg.keepalive_ether_type <= i_cfg_data[15:0];
                REG_LENGTH:     r_cfg.keepalive_length     <= i_cfg_data[13:0];
                REG_DEST_MAC:   r_cfg.keepalive_dest_mac   <= i_cfg_data[47:0];
                REG_INSTANCE:   r_cfg.instance_id          <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Front: classify each request
    wkl_front u_front (
        .i_req (i_req),
        .i_cfg (r_cfg),
        .o_cmd (w_cmd)
    );

    // Command queue between front and back
    wkl_fifo #(
        .W ($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (w_cmd),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_rdata (w_q_cmd),
        .o_empty (w_q_empty)
    );

    // Back: walk the slot table and build the result
    wkl_back #(
        .MAX_WORKERS (MAX_WORKERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_q_cmd),
        .i_cmd_valid (!w_q_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res       (w_res),
        .o_res_push  (w_res_push)
    );

    // Output queue parts the back end from the receiver
    wkl_fifo #(
        .W ($bits(t_out_req))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_wdata (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_rdata (o_res),
        .o_empty (empty)
    );

endmodule

// File: rtl/core/wkl_fifo.sv
module wkl_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);

    // Two-entry queue
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         w_do_push;
    logic         w_do_pop;

    assign o_full    = (r_cnt == 2'd2);
    assign o_empty   = (r_cnt == 2'd0);
    assign o_rdata   = r_mem[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wp <= ~r_wp;
            end
            if (w_do_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// File: rtl/core/wkl_front.sv
module wkl_front
    import wkl_pkg::*;
(
    input  t_in_req i_req,
    input  t_cfg    i_cfg,
    output t_cmd    o_cmd
);

    logic w_match;

    assign w_match = (i_req.frame_length == i_cfg.keepalive_length)
                  && (i_req.frame_ether_type == i_cfg.keepalive_ether_type)
                  && (i_req.frame_dest_mac == i_cfg.keepalive_dest_mac);

    // Classify the request into a back-end command
    always_comb begin
        o_cmd              = '0;
        o_cmd.mac          = i_req.frame_src_mac;
        o_cmd.delay        = i_req.reported_delay_ms;
        o_cmd.now          = i_req.now_seconds;
        case (i_req.opcode)
            OP_CHECK: begin
                o_cmd.is_keepalive = w_match;
                o_cmd.kind         = w_match ? CMD_KEEPALIVE : CMD_NONE;
            end
            OP_SWEEP:   o_cmd.kind = CMD_SWEEP;
            OP_REWRITE: o_cmd.kind = CMD_REWRITE;
            default:    o_cmd.kind = CMD_NONE;
        endcase
    end

endmodule

// File: rtl/core/wkl_back.sv
module wkl_back
    import wkl_pkg::*;
#(
    parameter int MAX_WORKERS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  t_cmd     i_cmd,
    input  logic     i_cmd_valid,
    output logic     o_cmd_pop,
    input  logic     i_res_full,
    output t_out_req o_res,
    output logic     o_res_push
);

    localparam int AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CW = $clog2(MAX_WORKERS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    t_slot             r_mem [MAX_WORKERS];
    t_slot             r_rd;
    logic [MAX_WORKERS-1:0] r_valid;

    logic [1:0]        r_state;
    t_cmd              r_cmd;
    logic [CW-1:0]     r_idx;
    logic              r_pend;
    logic [AW-1:0]     r_pidx;

    logic              r_hit;
    logic [AW-1:0]     r_hit_idx;
    logic              r_free;
    logic [AW-1:0]     r_free_idx;
    logic              r_found;
    logic [31:0]       r_best_delay;
    logic [47:0]       r_best_mac;

    logic              r_chosen_valid;
    logic [47:0]       r_chosen_mac;
    logic              n_chosen_valid;
    logic [47:0]       n_chosen_mac;

    logic              w_issue;
    logic [31:0]       w_age;
    logic              w_pvalid;

    assign w_issue   = (r_state == ST_SCAN) && (r_idx != CW'(MAX_WORKERS));
    assign w_age     = r_cmd.now - r_rd.last_seen;
    assign w_pvalid  = r_valid[r_pidx];
    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid && !i_res_full;
    assign o_res_push = (r_state == ST_DONE);

    // Selection after this command
    always_comb begin
        n_chosen_valid = r_chosen_valid;
        n_chosen_mac   = r_chosen_mac;
        if (r_cmd.kind == CMD_SWEEP) begin
            n_chosen_valid = r_found;
            n_chosen_mac   = r_found ? r_best_mac : 48'd0;
        end
    end

    always_comb begin
        o_res                   = '0;
        o_res.is_keepalive      = r_cmd.is_keepalive;
        o_res.table_full        = (r_cmd.kind == CMD_KEEPALIVE) && !r_hit && !r_free;
        o_res.worker_valid      = n_chosen_valid;
        o_res.worker_mac        = n_chosen_mac;
        o_res.rewritten_src_mac = {SRC_PREFIX, i_cfg.instance_id};
        o_res.drop_frame        = (r_cmd.kind == CMD_REWRITE) && !r_chosen_valid;
    end

    // Slot memory: one registered read port, one write port
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
        if (r_state == ST_DONE && r_cmd.kind == CMD_KEEPALIVE) begin
            if (r_hit) begin
                r_mem[r_hit_idx] <= '{mac: r_cmd.mac, last_seen: r_cmd.now,
                                      delay: r_cmd.delay};
            end else if (r_free) begin
                r_mem[r_free_idx] <= '{mac: r_cmd.mac, last_seen: r_cmd.now,
                                       delay: r_cmd.delay};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_SCAN && r_pend) begin
            if (r_cmd.kind == CMD_KEEPALIVE) begin
                if (w_pvalid && r_rd.mac == r_cmd.mac && !r_hit) begin
                    r_hit_idx <= r_pidx;
                end
                if (!w_pvalid && !r_free) begin
                    r_free_idx <= r_pidx;
                end
            end else if (w_pvalid && w_age >= {24'd0, i_cfg.timeout_seconds}) begin
            end else if (w_pvalid && (!r_found || r_rd.delay < r_best_delay)) begin
                r_best_delay <= r_rd.delay;
                r_best_mac   <= r_rd.mac;
            end
        end
        if (w_issue) begin
            r_pidx <= r_idx[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_valid        <= '0;
            r_idx          <= '0;
            r_pend         <= 1'b0;
            r_hit          <= 1'b0;
            r_free         <= 1'b0;
            r_found        <= 1'b0;
            r_chosen_valid <= 1'b0;
            r_chosen_mac   <= 48'd0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_cmd_pop) begin
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_hit   <= 1'b0;
                        r_free  <= 1'b0;
                        r_found <= 1'b0;
                        if (i_cmd.kind == CMD_KEEPALIVE || i_cmd.kind == CMD_SWEEP) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_SCAN: begin
                    r_pend <= w_issue;
                    if (w_issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (r_pend) begin
                        if (r_cmd.kind == CMD_KEEPALIVE) begin
                            if (w_pvalid && r_rd.mac == r_cmd.mac) begin
                                r_hit <= 1'b1;
                            end
                            if (!w_pvalid) begin
                                r_free <= 1'b1;
                            end
                        end else if (w_pvalid) begin
                            if (w_age >= {24'd0, i_cfg.timeout_seconds}) begin
                                r_valid[r_pidx] <= 1'b0;
                            end else begin
                                r_found <= 1'b1;
                            end
                        end
                    end
                    if (!w_issue && !r_pend) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (r_cmd.kind == CMD_KEEPALIVE && !r_hit && r_free) begin
                        r_valid[r_free_idx] <= 1'b1;
                    end
                    r_chosen_valid <= n_chosen_valid;
                    r_chosen_mac   <= n_chosen_mac;
                    r_state        <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: tb/worker_keepalive_table_least_delay_top_tb.sv
module worker_keepalive_table_least_delay_top_tb;
    import wkl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS   = 16;
    localparam int POOL_SIZE   = 24;      // more MACs than slots, so the table overflows
    localparam int HOLD_LEN    = 300;     // long receiver hold-off, in cycles
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_SHOWN   = 10;

    // Opcode 3 has no meaning; the block must answer it with the keepalive, table-full and drop flags low.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             push;
    t_in_req          i_req;
    logic             full;
    logic             empty;
    logic             pop;
    t_out_req         o_res;
    logic             i_cfg_we;
    logic [2:0]       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    worker_keepalive_table_least_delay_top #(
        .MAX_WORKERS(NUM_SLOTS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_req      (i_req),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the worker table, the selection and the registers
    // ------------------------------------------------------------------
    t_cfg                 cfg;
    logic [NUM_SLOTS-1:0] live;
    logic [47:0]          slot_mac   [NUM_SLOTS];
    logic [31:0]          slot_seen  [NUM_SLOTS];
    logic [31:0]          slot_delay [NUM_SLOTS];
    logic                 sel_valid;
    logic [47:0]          sel_mac;

    // Results still owed by the block, oldest first
    t_out_req replies_due[$];

    // Traffic shaping shared by the sender and the receiver
    int idle_pct;
    int stall_pct;
    logic hold_req;
    logic hold_seen;
    int hold_left;

    // Random traffic state: worker MACs in play and the current second
    logic [47:0] mac_pool [POOL_SIZE];
    logic [31:0] now_s;

    int cycle_count;
    int n_sent;
    int n_checked;
    int mismatches;
    int n_keepalive;
    int n_full;
    int n_drop;

    // Apply one request to the shadow table and return the result it owes.
    function automatic t_out_req worker_table_apply(input t_in_req r);
        t_out_req o;
        int i;
        int free_idx;
        int best;
        bit hit;
        bit found;
        logic [31:0] age;
        o = '0;
        if (r.opcode == OP_CHECK) begin
            o.is_keepalive = (r.frame_length == cfg.keepalive_length) &&
                             (r.frame_ether_type == cfg.keepalive_ether_type) &&
                             (r.frame_dest_mac == cfg.keepalive_dest_mac);
            if (o.is_keepalive) begin
                // Refresh a known worker, else take the lowest free slot.
                hit = 1'b0;
                free_idx = NUM_SLOTS;
                for (i = 0; i < NUM_SLOTS && !hit; i++) begin
                    if (live[i]) begin
                        if (slot_mac[i] == r.frame_src_mac) begin
                            slot_seen[i]  = r.now_seconds;
                            slot_delay[i] = r.reported_delay_ms;
                            hit = 1'b1;
                        end
                    end else if (free_idx == NUM_SLOTS) begin
                        free_idx = i;
                    end
                end
                if (!hit) begin
                    if (free_idx == NUM_SLOTS) begin
                        o.table_full = 1'b1;
                    end else begin
                        live[free_idx]       = 1'b1;
                        slot_mac[free_idx]   = r.frame_src_mac;
                        slot_seen[free_idx]  = r.now_seconds;
                        slot_delay[free_idx] = r.reported_delay_ms;
                    end
                end
            end
        end else if (r.opcode == OP_SWEEP) begin
            // Age with 32-bit wrap; drop the stale, keep the fastest survivor.
            found = 1'b0;
            best = 0;
            for (i = 0; i < NUM_SLOTS; i++) begin
                if (live[i]) begin
                    age = r.now_seconds - slot_seen[i];
                    if (age >= {24'd0, cfg.timeout_seconds}) begin
                        live[i] = 1'b0;
                    end else if (!found || slot_delay[i] < slot_delay[best]) begin
                        found = 1'b1;
                        best = i;
                    end
                end
            end
            sel_valid = found;
            sel_mac   = found ? slot_mac[best] : '0;
        end else if (r.opcode == OP_REWRITE) begin
            o.drop_frame = !sel_valid;
        end
        o.worker_valid      = sel_valid;
        o.worker_mac        = sel_mac;
        o.rewritten_src_mac = {SRC_PREFIX, cfg.instance_id};
        return o;
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[47:0];
    endfunction

    // ------------------------------------------------------------------
    // Cycle counter and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, replies_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Count down a receiver hold-off each time the test toggles hold_req.
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Result side: sample at the falling edge, where empty, pop and o_res
    // are stable, so the result taken at the next rising edge is known
    // without racing the block's own updates.
    // ------------------------------------------------------------------
    task automatic check_result(input t_out_req got);
        t_out_req want;
        bit bad;
        n_checked++;
        if (replies_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
                $display("cycle %0d: result with nothing owed:", cycle_count);
                $display("  ka=%0b full=%0b wv=%0b wmac=%h src=%h drop=%0b",
                         got.is_keepalive, got.table_full, got.worker_valid,
                         got.worker_mac, got.rewritten_src_mac, got.drop_frame);
            end
        end else begin
            want = replies_due.pop_front();
            bad = (got.is_keepalive !== want.is_keepalive) ||
                  (got.table_full !== want.table_full) ||
                  (got.worker_valid !== want.worker_valid) ||
                  (got.worker_mac !== want.worker_mac) ||
                  (got.rewritten_src_mac !== want.rewritten_src_mac) ||
                  (got.drop_frame !== want.drop_frame);
            if (bad) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("cycle %0d: result %0d differs", cycle_count, n_checked);
                    $display("  expected ka=%0b full=%0b wv=%0b wmac=%h src=%h drop=%0b",
                             want.is_keepalive, want.table_full, want.worker_valid,
                             want.worker_mac, want.rewritten_src_mac, want.drop_frame);
                    $display("  actual   ka=%0b full=%0b wv=%0b wmac=%h src=%h drop=%0b",
                             got.is_keepalive, got.table_full, got.worker_valid,
                             got.worker_mac, got.rewritten_src_mac, got.drop_frame);
                end
            end
            n_keepalive += int'(want.is_keepalive);
            n_full      += int'(want.table_full);
            n_drop      += int'(want.drop_frame);
        end
    endtask

    initial begin : result_side
        t_out_req got;
        bit taken;
        pop = 1'b0;
        hold_seen = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            taken = pop && !empty;
            got = o_res;
            @(posedge i_clk);
            if (taken) begin
                check_result(got);
            end
            // Hold pop low during reset and any hold-off, else stall at random.
            pop <= i_rst_n && (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Request side. Every task below starts and ends just after a rising
    // edge, so push only ever gets one assignment per time step.
    // ------------------------------------------------------------------
    task automatic send_req(input t_in_req r);
        int gap;
        bit took;
        gap = 0;
        while (idle_pct != 0 && gap < 40 && $urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push  <= 1'b1;
        i_req <= r;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = !full;
            @(posedge i_clk);
        end
        replies_due.push_back(worker_table_apply(r));
        n_sent++;
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (replies_due.size() != 0);
    endtask

    // Write all five registers back to back; hold the enable high throughout.
    task automatic set_config(input t_cfg c);
        logic [CFG_W-1:0] val [5];
        logic [2:0] idx_of [5];
        int k;
        idx_of = '{REG_TIMEOUT, REG_ETHER_TYPE, REG_LENGTH, REG_DEST_MAC, REG_INSTANCE};
        val[0] = CFG_W'(c.timeout_seconds);
        val[1] = CFG_W'(c.keepalive_ether_type);
        val[2] = CFG_W'(c.keepalive_length);
        val[3] = CFG_W'(c.keepalive_dest_mac);
        val[4] = CFG_W'(c.instance_id);
        for (k = 0; k < 5; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_of[k];
            i_cfg_data <= val[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg = c;
    endtask

    function automatic t_in_req field_request(input logic [1:0] op, input logic [13:0] len,
                                              input logic [15:0] et, input logic [47:0] dmac,
                                              input logic [47:0] smac, input logic [31:0] dly,
                                              input logic [31:0] now);
        t_in_req r;
        r.opcode            = op;
        r.frame_length      = len;
        r.frame_ether_type  = et;
        r.frame_dest_mac    = dmac;
        r.frame_src_mac     = smac;
        r.reported_delay_ms = dly;
        r.now_seconds       = now;
        return r;
    endfunction

    // Random request: mostly well-formed keepalives from a small worker pool,
    // sweeps and rewrites at the running time, plus some noise.
    function automatic t_in_req make_item();
        t_in_req r;
        int pick;
        r = field_request(2'($urandom_range(3)), 14'($urandom()), 16'($urandom()), rand48(),
                          rand48(), $urandom(), $urandom());
        // Advance the clock now and then, sometimes far enough to age everyone out.
        pick = $urandom_range(99);
        if (pick < 10) now_s = now_s + $urandom_range(0, 3);
        if (pick < 2)  now_s = now_s + $urandom_range(0, 400);
        pick = $urandom_range(99);
        if (pick < 50) begin
            r.opcode = OP_CHECK;
            if ($urandom_range(99) < 80) begin
                r.frame_length     = cfg.keepalive_length;
                r.frame_ether_type = cfg.keepalive_ether_type;
                r.frame_dest_mac   = cfg.keepalive_dest_mac;
                r.frame_src_mac    = ($urandom_range(9) == 0)
                                   ? rand48() : mac_pool[$urandom_range(POOL_SIZE - 1)];
                // Small delays give ties; the rest spread over the full word.
                r.reported_delay_ms = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 7);
                r.now_seconds = ($urandom_range(9) == 0) ? now_s - $urandom_range(0, 3) : now_s;
                // Break one match field by a single bit now and then.
                case ($urandom_range(11))
                    0: r.frame_length[$urandom_range(13)] ^= 1'b1;
                    1: r.frame_ether_type[$urandom_range(15)] ^= 1'b1;
                    2: r.frame_dest_mac[$urandom_range(47)] ^= 1'b1;
                    default: ;
                endcase
            end
        end else if (pick < 70) begin
            r.opcode = OP_SWEEP;
            if ($urandom_range(9) != 0) r.now_seconds = now_s;
        end else if (pick < 96) begin
            r.opcode = OP_REWRITE;
        end else begin
            r.opcode = OP_UNUSED;
        end
        return r;
    endfunction

    task automatic run_phase(input t_cfg c, input int idle, input int stall, input int count);
        int k;
        drain();
        set_config(c);
        for (k = 0; k < POOL_SIZE; k++) mac_pool[k] = rand48();
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        // Start some phases just before the 32-bit second counter wraps.
        now_s = ($urandom_range(1) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15) : $urandom();
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count) send_req(make_item());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults: empty selection, unused opcode, and near-miss frames.
    task automatic test_classify();
        idle_pct  = 0;
        stall_pct = 0;
        send_req(field_request(OP_REWRITE, '1, '1, '1, '1, '1, '1));
        send_req(field_request(OP_SWEEP, '0, '0, '0, '0, '0, '0));
        send_req(field_request(OP_UNUSED, '1, '1, '1, '1, '1, '1));
        send_req(field_request(OP_CHECK, '0, '0, '0, '0, '0, '0));
        send_req(field_request(OP_CHECK, 14'd17, 16'h9000, RST_DEST_MAC, 48'h1, 32'd1, 32'd0));
        // Ether type in the other byte order must not match.
        send_req(field_request(OP_CHECK, 14'd18, 16'h0090, RST_DEST_MAC, 48'h1, 32'd1, 32'd0));
        send_req(field_request(OP_CHECK, 14'd18, 16'h9000, 48'hFF00_0000_0001, 48'h1, 32'd1,
                               32'd0));
    endtask

    // Fill all slots, overflow by one, then select across a delay tie and
    // a counter wrap; the winner has an all-zero MAC.
    task automatic test_table_full_and_select();
        int k;
        logic [47:0] mac;
        logic [31:0] dly;
        for (k = 0; k < NUM_SLOTS; k++) begin
            mac = (k == 0) ? 48'd0 : (k == NUM_SLOTS - 1) ? '1 : rand48();
            dly = (k == 0 || k == 9) ? 32'd3 : (k == NUM_SLOTS - 1) ? '1 : 32'd100 + k;
            send_req(field_request(OP_CHECK, RST_LENGTH, RST_ETHER_TYPE, RST_DEST_MAC, mac, dly,
                                   32'hFFFF_FFFF));
        end
        send_req(field_request(OP_CHECK, RST_LENGTH, RST_ETHER_TYPE, RST_DEST_MAC,
                               48'h0000_0BAD_F00D, '0, 32'hFFFF_FFFF));
        send_req(field_request(OP_SWEEP, '0, '0, '0, '0, '0, 32'd0));
        send_req(field_request(OP_REWRITE, '0, '0, '0, '0, '0, '0));
    endtask

    // Random traffic under six register settings, extremes included,
    // cycling through the idle and stall patterns.
    task automatic test_config_settings();
        t_cfg c;
        c = '{timeout_seconds: 8'd3, keepalive_ether_type: 16'h0000, keepalive_length: 14'd0,
              keepalive_dest_mac: 48'd0, instance_id: 24'hFF_FFFF};
        run_phase(c, 0, 0, 300);
        // Zero timeout: every sweep empties the table.
        c = '{timeout_seconds: 8'd0, keepalive_ether_type: 16'hFFFF, keepalive_length: 14'h3FFF,
              keepalive_dest_mac: '1, instance_id: 24'd0};
        run_phase(c, 71, 0, 300);
        c = '{timeout_seconds: 8'd255, keepalive_ether_type: 16'($urandom()),
              keepalive_length: 14'($urandom()), keepalive_dest_mac: rand48(),
              instance_id: 24'($urandom())};
        run_phase(c, 0, 71, 300);
        c = '{timeout_seconds: 8'd1, keepalive_ether_type: RST_ETHER_TYPE,
              keepalive_length: RST_LENGTH, keepalive_dest_mac: RST_DEST_MAC,
              instance_id: 24'($urandom())};
        run_phase(c, 34, 34, 300);
        c = '{timeout_seconds: 8'($urandom_range(0, 10)), keepalive_ether_type: 16'($urandom()),
              keepalive_length: 14'($urandom()), keepalive_dest_mac: rand48(),
              instance_id: 24'($urandom())};
        run_phase(c, 0, 0, 300);
        c = '{timeout_seconds: 8'($urandom()), keepalive_ether_type: 16'($urandom()),
              keepalive_length: 14'($urandom()), keepalive_dest_mac: rand48(),
              instance_id: 24'($urandom())};
        run_phase(c, 34, 34, 200);
    endtask

    // Hold the receiver off while the sender keeps pushing, so the output
    // and command queues fill and full rises; then pause until all is back and send again.
    task automatic test_backpressure();
        t_cfg c;
        c = '{timeout_seconds: 8'd4, keepalive_ether_type: RST_ETHER_TYPE,
              keepalive_length: RST_LENGTH, keepalive_dest_mac: RST_DEST_MAC,
              instance_id: 24'($urandom())};
        run_phase(c, 0, 0, 10);
        hold_req = ~hold_req;
        repeat (40) send_req(make_item());
        drain();
        repeat (20) send_req(make_item());
    endtask

    initial begin : stimulus
        push        = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        hold_req    = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        cycle_count = 0;
        n_sent      = 0;
        n_checked   = 0;
        mismatches  = 0;
        n_keepalive = 0;
        n_full      = 0;
        n_drop      = 0;
        now_s       = '0;

        // Mirror the block's reset: defaults loaded, table and selection empty.
        cfg = '{timeout_seconds: RST_TIMEOUT, keepalive_ether_type: RST_ETHER_TYPE,
                keepalive_length: RST_LENGTH, keepalive_dest_mac: RST_DEST_MAC,
                instance_id: RST_INSTANCE};
        live      = '0;
        sel_valid = 1'b0;
        sel_mac   = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_classify();
        test_table_full_and_select();
        test_config_settings();
        test_backpressure();

        // Drain, then give the slowest walk time to show any stray result.
        drain();
        repeat (NUM_SLOTS + 8) @(posedge i_clk);

        $display("Sent %0d requests (%0d keepalives, %0d table-full, %0d drops) over reset",
                 n_sent, n_keepalive, n_full, n_drop);
        $display("defaults, six register settings and a long receiver hold; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
